// File: sv/odst_pkg.sv
package odst_pkg;

    localparam int STEP_W = 4;
    localparam int STEPS  = 9;
    localparam int DATE_W = 9;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_LOOKUP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_TAKE,
        UOP_RDIDX,
        UOP_GRAB,
        UOP_SHIFT,
        UOP_DEC,
        UOP_SEARCH,
        UOP_RESOLVE,
        UOP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_ACCEPT,
        COND_FIND,
        COND_BADPOS,
        COND_READ,
        COND_SHIFTEND,
        COND_SCANEND,
        COND_OUTFREE
    } t_cond;

    typedef struct packed {
        t_uop              op;
        t_cond             cond;
        logic              hold;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DECODE  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CHKPOS  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_GETENT  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SHIFT   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DROP    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SEARCH  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_RESOLVE = 4'd7;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd8;

    // on cond: jump to target; else stay when hold, otherwise fall through
    localparam t_ctrl PROGRAM [STEPS] = '{
        '{op: UOP_TAKE,    cond: COND_ACCEPT,   hold: 1'b1, target: STEP_DECODE},
        '{op: UOP_NONE,    cond: COND_FIND,     hold: 1'b0, target: STEP_SEARCH},
        '{op: UOP_RDIDX,   cond: COND_BADPOS,   hold: 1'b0, target: STEP_EMIT},
        '{op: UOP_GRAB,    cond: COND_READ,     hold: 1'b0, target: STEP_EMIT},
        '{op: UOP_SHIFT,   cond: COND_SHIFTEND, hold: 1'b1, target: STEP_DROP},
        '{op: UOP_DEC,     cond: COND_ALWAYS,   hold: 1'b0, target: STEP_EMIT},
        '{op: UOP_SEARCH,  cond: COND_SCANEND,  hold: 1'b1, target: STEP_RESOLVE},
        '{op: UOP_RESOLVE, cond: COND_ALWAYS,   hold: 1'b0, target: STEP_EMIT},
        '{op: UOP_EMIT,    cond: COND_OUTFREE,  hold: 1'b1, target: STEP_FETCH}
    };

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:                      len = 5'd29;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        len = 5'd31;
            default:                   len = 5'd0;
        endcase
        return len;
    endfunction

    // packed date: day in [8:4], month in [3:0]
    function automatic logic [DATE_W-1:0] normalize(input logic [4:0] day,
                                                    input logic [3:0] month);
        logic [4:0] d;
        d = day;
        if (month < 4'd1 || month > 4'd12) begin
            return {5'd1, 4'd1};
        end
        if (d < 5'd1 || d > month_len(month)) begin
            d = 5'd1;
        end
        return {d, month};
    endfunction

endpackage

// File: sv/ordered_date_set_table_top.sv
// Insertion-ordered set of (day, month) dates without duplicates, DEPTH entries deep.
// A short control program in a step table runs one command at a time over a
// single-port-read, single-port-write entry memory. Add and lookup scan the
// held entries one per cycle; remove closes the gap one entry per cycle. The
// scan and the gap shift are bound by the one memory read port. A finished
// result sits in the output register, so the next command is taken while it
// waits; a command stalls only at its own result if that register is still
// occupied. Entry memory needs no clearing after reset.
module ordered_date_set_table_top
    import odst_pkg::*;
#(
    parameter int DEPTH = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [4:0] i_day_in,
    input  logic [3:0] i_month_in,
    input  logic [8:0] i_index_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic       o_found,
    output logic [8:0] o_position,
    output logic [4:0] o_day_out,
    output logic [3:0] o_month_out,
    output logic [9:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATE_W-1:0] mem [DEPTH];

    logic [STEP_W-1:0] r_pc, n_pc;
    t_ctrl             ctrl;
    logic              cond_ok;

    t_cmd              r_cmd;
    logic [DATE_W-1:0] r_date;
    logic [8:0]        r_idx;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_ptr;
    logic [AW-1:0]     r_wptr;
    logic              r_pend;
    logic              r_hit;
    t_status           r_status;
    logic              r_found;
    logic [8:0]        r_pos;
    logic [DATE_W-1:0] r_rd_data;
    logic              r_out_valid;

    logic              in_fire;
    logic              out_free;
    logic              bad_pos;
    logic              match;
    logic              scan_end;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign ctrl       = PROGRAM[r_pc];
    assign o_in_stall = (ctrl.op != UOP_TAKE);
    assign in_fire    = i_in_valid && (ctrl.op == UOP_TAKE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign bad_pos    = {1'b0, r_idx} >= 10'(r_count);
    assign match      = r_pend && (r_rd_data == r_date);
    assign scan_end   = match || (r_ptr == r_count);
    assign o_out_valid = r_out_valid;

    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_ACCEPT:   cond_ok = in_fire;
            COND_FIND:     cond_ok = (r_cmd == CMD_ADD) || (r_cmd == CMD_LOOKUP);
            COND_BADPOS:   cond_ok = bad_pos;
            COND_READ:     cond_ok = (r_cmd == CMD_READ);
            COND_SHIFTEND: cond_ok = (r_ptr == r_count) && !r_pend;
            COND_SCANEND:  cond_ok = scan_end;
            COND_OUTFREE:  cond_ok = out_free;
            default:       cond_ok = 1'b1;
        endcase
        if (cond_ok) begin
            n_pc = ctrl.target;
        end else if (ctrl.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + STEP_W'(1);
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wptr;
        mem_wdata = r_rd_data;
        mem_re    = 1'b0;
        mem_raddr = r_ptr[AW-1:0];
        case (ctrl.op)
            UOP_RDIDX: begin
                mem_re    = !bad_pos;
                mem_raddr = r_idx[AW-1:0];
            end
            UOP_SHIFT: begin
                mem_we = r_pend;
                mem_re = (r_ptr != r_count);
            end
            UOP_SEARCH: begin
                mem_re = !match && (r_ptr != r_count);
            end
            UOP_RESOLVE: begin
                mem_we    = !r_hit && (r_cmd == CMD_ADD) && (r_count != CW'(DEPTH));
                mem_waddr = r_count[AW-1:0];
                mem_wdata = r_date;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_FETCH;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (ctrl.op == UOP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (ctrl.op)
                UOP_TAKE: begin
                    if (in_fire) begin
                        r_cmd  <= t_cmd'(i_command);
                        r_date <= normalize(i_day_in, i_month_in);
                        r_idx  <= i_index_in;
                        r_ptr  <= '0;
                        r_pend <= 1'b0;
                        r_hit  <= 1'b0;
                    end
                end
                UOP_RDIDX: begin
                    r_found <= 1'b0;
                    r_pos   <= r_idx;
                    if (bad_pos) begin
                        r_status <= ST_BADPOS;
                        r_date   <= '0;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                UOP_GRAB: begin
                    r_date <= r_rd_data;
                    r_ptr  <= CW'(r_idx) + CW'(1);
                    r_wptr <= r_idx[AW-1:0];
                    r_pend <= 1'b0;
                end
                UOP_SHIFT: begin
                    // write the entry fetched last cycle one slot down
                    if (r_pend) begin
                        r_wptr <= r_wptr + AW'(1);
                    end
                    if (r_ptr != r_count) begin
                        r_ptr  <= r_ptr + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                UOP_DEC: begin
                    r_count <= r_count - CW'(1);
                end
                UOP_SEARCH: begin
                    // compare the entry fetched last cycle, fetch the next one
                    if (match) begin
                        r_hit <= 1'b1;
                        r_pos <= 9'(r_ptr - CW'(1));
                    end else if (r_ptr != r_count) begin
                        r_ptr  <= r_ptr + CW'(1);
                        r_pend <= 1'b1;
                    end
                end
                UOP_RESOLVE: begin
                    r_pend <= 1'b0;
                    if (r_hit) begin
                        r_found  <= 1'b1;
                        r_status <= (r_cmd == CMD_ADD) ? ST_DUP : ST_OK;
                    end else if (r_cmd == CMD_LOOKUP) begin
                        r_found  <= 1'b0;
                        r_status <= ST_OK;
                        r_pos    <= '0;
                    end else if (r_count == CW'(DEPTH)) begin
                        r_found  <= 1'b0;
                        r_status <= ST_FULL;
                        r_pos    <= '0;
                    end else begin
                        r_found  <= 1'b0;
                        r_status <= ST_OK;
                        r_pos    <= 9'(r_count);
                        r_count  <= r_count + CW'(1);
                    end
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    // result beat register; loaded only when the slot is free
    always_ff @(posedge i_clk) begin
        if (ctrl.op == UOP_EMIT && out_free) begin
            o_status    <= r_status;
            o_found     <= r_found;
            o_position  <= r_pos;
            o_day_out   <= r_date[8:4];
            o_month_out <= r_date[3:0];
            o_count     <= 10'(r_count);
        end
    end

endmodule
